>>> src/hilbert_3d_index_to_coords_macros.svh
// Assertion helpers shared by the RTL.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef HILBERT_3D_INDEX_TO_COORDS_MACROS_SVH
`define HILBERT_3D_INDEX_TO_COORDS_MACROS_SVH

// Condition that must hold at every clock edge.
`define HILB3_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When ante holds, cons must hold at the next clock edge.
`define HILB3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/hilb3_pkg.sv
`timescale 1ns / 1ps

package hilb3_pkg;

    localparam int INDEX_W       = 30;
    localparam int POS_W         = 12;
    localparam int ORDER_W       = 4;
    localparam int ORDER_RESET   = 5;
    localparam int SPACING_SHIFT = 2;

    typedef logic [ORDER_W-1:0] order_t;

    typedef struct packed {
        logic [INDEX_W-1:0] hilbert_index;
    } idx_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } pos_item_t;

    // One octant step: next curve state and the transformed octant (z, y, x bits).
    typedef struct packed {
        logic [2:0] state;
        logic [2:0] octant;
    } hilb3_step_t;

    localparam logic [2:0] NEXT_STATE [8][8] = '{
        '{3'd0, 3'd3, 3'd4, 3'd7, 3'd6, 3'd1, 3'd2, 3'd5},
        '{3'd7, 3'd0, 3'd5, 3'd2, 3'd1, 3'd6, 3'd3, 3'd4},
        '{3'd6, 3'd7, 3'd2, 3'd5, 3'd4, 3'd3, 3'd0, 3'd1},
        '{3'd1, 3'd6, 3'd3, 3'd0, 3'd7, 3'd4, 3'd5, 3'd2},
        '{3'd2, 3'd5, 3'd6, 3'd1, 3'd0, 3'd7, 3'd4, 3'd3},
        '{3'd3, 3'd4, 3'd7, 3'd6, 3'd5, 3'd2, 3'd1, 3'd0},
        '{3'd4, 3'd1, 3'd0, 3'd3, 3'd2, 3'd5, 3'd6, 3'd7},
        '{3'd5, 3'd2, 3'd1, 3'd4, 3'd3, 3'd0, 3'd7, 3'd6}
    };

    localparam logic [2:0] OCTANT_MAP [8][8] = '{
        '{3'd0, 3'd1, 3'd3, 3'd2, 3'd6, 3'd7, 3'd5, 3'd4},
        '{3'd2, 3'd3, 3'd1, 3'd0, 3'd4, 3'd5, 3'd7, 3'd6},
        '{3'd4, 3'd5, 3'd7, 3'd6, 3'd0, 3'd1, 3'd3, 3'd2},
        '{3'd6, 3'd7, 3'd5, 3'd4, 3'd2, 3'd3, 3'd1, 3'd0},
        '{3'd1, 3'd0, 3'd2, 3'd3, 3'd7, 3'd6, 3'd4, 3'd5},
        '{3'd3, 3'd2, 3'd0, 3'd1, 3'd5, 3'd4, 3'd6, 3'd7},
        '{3'd5, 3'd4, 3'd6, 3'd7, 3'd1, 3'd0, 3'd2, 3'd3},
        '{3'd7, 3'd6, 3'd4, 3'd5, 3'd3, 3'd2, 3'd0, 3'd1}
    };

    function automatic hilb3_step_t hilb3_step(input logic [2:0] state,
                                               input logic [2:0] oct);
        hilb3_step_t r;
        r.state  = NEXT_STATE[state][oct];
        r.octant = OCTANT_MAP[state][oct];
        return r;
    endfunction

endpackage

>>> src/hilb3_chan_if.sv
`timescale 1ns / 1ps

interface hilb3_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/hilbert_3d_index_to_coords.sv
`timescale 1ns / 1ps
// 3D Hilbert index decoder: index along the curve -> centered grid position.
//
// Channels (valid/ready, a transfer happens when both are high at a clock edge):
//   idx : sink, one hilbert_index per transfer (low 3*curve_order bits used).
//   pos : source, one pos_x/pos_y/pos_z result per accepted index, in order.
//   cfg : sink, writes curve_order; always ready. Write only while idle.
// Each coordinate c is returned as (c - 2^(order-1)) * 4, a signed 12-bit value.
// curve_order 0 acts as 1, values above MAX_ORDER act as MAX_ORDER.
//
// The index transfer loads the input register, the upper half of the octant
// steps fills the middle register, the lower half plus the centering fills
// the result register, which drives pos.
// Throughput: one index per cycle while pos is ready; the rate is set by the three-register
// pipeline, each register advancing whenever the one after it moves or is empty.
// When pos stalls, results hold in place and the pipe keeps filling its empty
// registers; idx.ready drops only when all three registers are full.
// Reset empties the pipeline and sets curve_order to 5 (clamped to MAX_ORDER).
`include "hilbert_3d_index_to_coords_macros.svh"

module hilbert_3d_index_to_coords
    import hilb3_pkg::*;
#(
    parameter int MAX_ORDER = 10
)
(
    input  logic          clk,
    input  logic          rst_n,
    hilb3_chan_if.sink    idx,
    hilb3_chan_if.sink    cfg,
    hilb3_chan_if.source  pos
);

    localparam int IDX_W      = 3 * MAX_ORDER;
    localparam int HI_STEPS   = (MAX_ORDER + 1) / 2;
    localparam int LO_STEPS   = MAX_ORDER - HI_STEPS;
    localparam int ORDER_INIT = (ORDER_RESET > MAX_ORDER) ? MAX_ORDER : ORDER_RESET;

    // Configuration register, stored already clamped to the legal range.
    order_t order_reg;
    order_t order_next;

    // Pipeline control.
    logic in_valid_reg,  in_valid_next;
    logic mid_valid_reg, mid_valid_next;
    logic out_valid_reg, out_valid_next;
    logic in_en, mid_en, out_en;

    // Pipeline payload.
    logic [IDX_W-1:0]     in_idx_reg;
    logic [IDX_W-1:0]     in_idx_next;
    logic [IDX_W-1:0]     idx_mask;
    logic [IDX_W-1:0]     mid_idx_reg;
    logic [2:0]           mid_state_reg, mid_state_next;
    logic [MAX_ORDER-1:0] mid_cx_reg, mid_cy_reg, mid_cz_reg;
    logic [MAX_ORDER-1:0] mid_cx_next, mid_cy_next, mid_cz_next;
    pos_item_t            out_pos_reg, out_pos_next;

    // ------------------------------------------------------------------
    // Configuration: always accept, clamp zero up and large orders down.
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_comb
    begin
        order_next = order_reg;
        if (cfg.valid)
        begin
            if (cfg.data == order_t'(0))
            begin
                order_next = order_t'(1);
            end
            else if (cfg.data > order_t'(MAX_ORDER))
            begin
                order_next = order_t'(MAX_ORDER);
            end
            else
            begin
                order_next = cfg.data;
            end
        end
    end

    // Keep only the low 3*order index bits. Leading zero octants leave the
    // curve state at 0 and add zero coordinate bits, so every index can then
    // run the full MAX_ORDER steps.
    always_comb
    begin
        for (int k = 0; k < IDX_W; k++)
        begin
            idx_mask[k] = (k < 3 * int'(order_reg));
        end
    end

    // ------------------------------------------------------------------
    // Handshake: each register advances when the next one moves or is empty.
    // ------------------------------------------------------------------
    assign out_en    = !out_valid_reg || pos.ready;
    assign mid_en    = !mid_valid_reg || out_en;
    assign in_en     = !in_valid_reg || mid_en;
    assign idx.ready = in_en;

    assign in_valid_next  = in_en  ? idx.valid     : in_valid_reg;
    assign mid_valid_next = mid_en ? in_valid_reg  : mid_valid_reg;
    assign out_valid_next = out_en ? mid_valid_reg : out_valid_reg;

    assign in_idx_next = idx.data.hilbert_index[IDX_W-1:0] & idx_mask;

    // ------------------------------------------------------------------
    // Upper octants, most significant first, from the input register.
    // ------------------------------------------------------------------
    always_comb
    begin
        hilb3_step_t stp;
        logic [2:0]  st;
        st          = 3'd0;
        mid_cx_next = '0;
        mid_cy_next = '0;
        mid_cz_next = '0;
        for (int i = MAX_ORDER - 1; i >= LO_STEPS; i--)
        begin
            stp         = hilb3_step(st, in_idx_reg[3*i +: 3]);
            mid_cx_next = (mid_cx_next << 1) | MAX_ORDER'(stp.octant[0]);
            mid_cy_next = (mid_cy_next << 1) | MAX_ORDER'(stp.octant[1]);
            mid_cz_next = (mid_cz_next << 1) | MAX_ORDER'(stp.octant[2]);
            st          = stp.state;
        end
        mid_state_next = st;
    end

    // ------------------------------------------------------------------
    // Lower octants, then center and scale by the spacing of 4.
    // ------------------------------------------------------------------
    always_comb
    begin
        hilb3_step_t          stp;
        logic [2:0]           st;
        logic [MAX_ORDER-1:0] cx, cy, cz;
        logic [POS_W-1:0]     half4;
        st = mid_state_reg;
        cx = mid_cx_reg;
        cy = mid_cy_reg;
        cz = mid_cz_reg;
        for (int i = LO_STEPS - 1; i >= 0; i--)
        begin
            stp = hilb3_step(st, mid_idx_reg[3*i +: 3]);
            cx  = (cx << 1) | MAX_ORDER'(stp.octant[0]);
            cy  = (cy << 1) | MAX_ORDER'(stp.octant[1]);
            cz  = (cz << 1) | MAX_ORDER'(stp.octant[2]);
            st  = stp.state;
        end
        // 2^(order-1) scaled by 4 is 2^(order+1).
        half4 = (POS_W'(1) << order_reg) << 1;
        out_pos_next.pos_x = $signed((POS_W'(cx) << SPACING_SHIFT) - half4);
        out_pos_next.pos_y = $signed((POS_W'(cy) << SPACING_SHIFT) - half4);
        out_pos_next.pos_z = $signed((POS_W'(cz) << SPACING_SHIFT) - half4);
    end

    assign pos.valid = out_valid_reg;
    assign pos.data  = out_pos_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg     <= order_t'(ORDER_INIT);
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            order_reg     <= order_next;
            in_valid_reg  <= in_valid_next;
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_en)
        begin
            in_idx_reg <= in_idx_next;
        end
        if (mid_en)
        begin
            mid_idx_reg   <= in_idx_reg;
            mid_state_reg <= mid_state_next;
            mid_cx_reg    <= mid_cx_next;
            mid_cy_reg    <= mid_cy_next;
            mid_cz_reg    <= mid_cz_next;
        end
        if (out_en)
        begin
            out_pos_reg <= out_pos_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `HILB3_ASSERT_ALWAYS(a_order_range,
        order_reg >= order_t'(1) && order_reg <= order_t'(MAX_ORDER),
        "curve order register out of range")
    `HILB3_ASSERT_ALWAYS(a_index_masked,
        !in_valid_reg || ((in_idx_reg & ~idx_mask) == '0),
        "index bits above 3*order reached the octant steps")
    `HILB3_ASSERT_NEXT(a_input_hold, in_valid_reg && !mid_en,
        in_valid_reg && $stable(in_idx_reg),
        "stalled input register lost or changed its index")
    `HILB3_ASSERT_NEXT(a_mid_to_out, mid_valid_reg && out_en, out_valid_reg,
        "middle stage result did not reach the result register")

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb
    import hilb3_pkg::*;
();

    // Depth of the decode pipeline, plus a little slack, used when the
    // block must be quiet before a curve_order write and at the end.
    localparam int PIPE_SETTLE = 8;
    localparam int ORDER_MAX   = 10;
    localparam int PHASE_ITEMS = 104;
    localparam int DIR_ROWS    = 20;

    // Transformed octant, indexed by [curve state][index octant].
    localparam logic [2:0] OCT_XFORM [8][8] = '{
        '{3'd0, 3'd1, 3'd3, 3'd2, 3'd6, 3'd7, 3'd5, 3'd4},
        '{3'd2, 3'd3, 3'd1, 3'd0, 3'd4, 3'd5, 3'd7, 3'd6},
        '{3'd4, 3'd5, 3'd7, 3'd6, 3'd0, 3'd1, 3'd3, 3'd2},
        '{3'd6, 3'd7, 3'd5, 3'd4, 3'd2, 3'd3, 3'd1, 3'd0},
        '{3'd1, 3'd0, 3'd2, 3'd3, 3'd7, 3'd6, 3'd4, 3'd5},
        '{3'd3, 3'd2, 3'd0, 3'd1, 3'd5, 3'd4, 3'd6, 3'd7},
        '{3'd5, 3'd4, 3'd6, 3'd7, 3'd1, 3'd0, 3'd2, 3'd3},
        '{3'd7, 3'd6, 3'd4, 3'd5, 3'd3, 3'd2, 3'd0, 3'd1}
    };

    // Curve state for the next (less significant) octant.
    localparam logic [2:0] STATE_NEXT [8][8] = '{
        '{3'd0, 3'd3, 3'd4, 3'd7, 3'd6, 3'd1, 3'd2, 3'd5},
        '{3'd7, 3'd0, 3'd5, 3'd2, 3'd1, 3'd6, 3'd3, 3'd4},
        '{3'd6, 3'd7, 3'd2, 3'd5, 3'd4, 3'd3, 3'd0, 3'd1},
        '{3'd1, 3'd6, 3'd3, 3'd0, 3'd7, 3'd4, 3'd5, 3'd2},
        '{3'd2, 3'd5, 3'd6, 3'd1, 3'd0, 3'd7, 3'd4, 3'd3},
        '{3'd3, 3'd4, 3'd7, 3'd6, 3'd5, 3'd2, 3'd1, 3'd0},
        '{3'd4, 3'd1, 3'd0, 3'd3, 3'd2, 3'd5, 3'd6, 3'd7},
        '{3'd5, 3'd2, 3'd1, 3'd4, 3'd3, 3'd0, 3'd7, 3'd6}
    };

    // One directed stimulus row. When known is set, the position is typed
    // in here; otherwise the decoder model below supplies it.
    typedef struct {
        order_t              ord;
        logic [INDEX_W-1:0]  index;
        bit                  known;
        int                  x;
        int                  y;
        int                  z;
    } dir_row_t;

    // Directed rows: reset order first (no write before it), then the order
    // extremes, zero and too-large orders, and ignored upper index bits.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{4'd5,  30'h0000_0000, 1'b1,   -64,   -64,   -64},
        '{4'd5,  30'h3FFF_8000, 1'b1,   -64,   -64,   -64},
        '{4'd5,  30'h3FFF_FFFF, 1'b0,     0,     0,     0},
        '{4'd5,  30'h0000_7FFF, 1'b0,     0,     0,     0},
        '{4'd5,  30'h0000_4924, 1'b0,     0,     0,     0},
        '{4'd1,  30'h0000_0000, 1'b1,    -4,    -4,    -4},
        '{4'd1,  30'h0000_0001, 1'b1,     0,    -4,    -4},
        '{4'd1,  30'h0000_0002, 1'b1,     0,     0,    -4},
        '{4'd1,  30'h0000_0003, 1'b1,    -4,     0,    -4},
        '{4'd1,  30'h0000_0004, 1'b1,    -4,     0,     0},
        '{4'd1,  30'h0000_0005, 1'b1,     0,     0,     0},
        '{4'd1,  30'h0000_0006, 1'b1,     0,    -4,     0},
        '{4'd1,  30'h3FFF_FFFF, 1'b1,    -4,    -4,     0},
        '{4'd0,  30'h0000_0007, 1'b1,    -4,    -4,     0},
        '{4'd0,  30'h3FFF_FFF8, 1'b1,    -4,    -4,    -4},
        '{4'd10, 30'h0000_0000, 1'b1, -2048, -2048, -2048},
        '{4'd10, 30'h3FFF_FFFF, 1'b0,     0,     0,     0},
        '{4'd10, 30'h1555_5555, 1'b0,     0,     0,     0},
        '{4'd15, 30'h0000_0000, 1'b1, -2048, -2048, -2048},
        '{4'd11, 30'h2AAA_AAAA, 1'b0,     0,     0,     0}
    };

    logic clk;
    logic rst_n;

    hilb3_chan_if #(.payload_t(idx_item_t)) idx_if ();
    hilb3_chan_if #(.payload_t(order_t))    cfg_if ();
    hilb3_chan_if #(.payload_t(pos_item_t)) pos_if ();

    hilbert_3d_index_to_coords #(
        .MAX_ORDER (ORDER_MAX)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .idx   (idx_if.sink),
        .cfg   (cfg_if.sink),
        .pos   (pos_if.source)
    );

    // Positions owed by the block, oldest first.
    pos_item_t pending_pos [$];
    order_t    cur_order;
    int        mismatch_count;
    int        burst_left;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Decode one index the way the block should: walk the octants from the
    // most significant down, shift the transformed octant bits into x/y/z,
    // then center on the grid and scale by the spacing of 4.
    function automatic pos_item_t decode_position(logic [INDEX_W-1:0] index, order_t ord);
        int unsigned        levels;
        int unsigned        lvl;
        logic [2:0]         curve_st;
        logic [2:0]         oct;
        logic [2:0]         xform;
        logic [9:0]         cx;
        logic [9:0]         cy;
        logic [9:0]         cz;
        logic [POS_W-1:0]   half_scaled;
        pos_item_t          r;
        // Order zero acts as one, anything above the maximum as the maximum.
        levels = (ord == 0) ? 1 : ((ord > ORDER_MAX) ? ORDER_MAX : ord);
        curve_st = 3'd0;
        cx = '0;
        cy = '0;
        cz = '0;
        for (lvl = levels; lvl > 0; lvl--)
        begin
            oct      = index[3*(lvl-1) +: 3];
            xform    = OCT_XFORM[curve_st][oct];
            cx       = {cx[8:0], xform[0]};
            cy       = {cy[8:0], xform[1]};
            cz       = {cz[8:0], xform[2]};
            curve_st = STATE_NEXT[curve_st][oct];
        end
        // 2^(order-1) times 4 is 2^(order+1).
        half_scaled = POS_W'(1) << (levels + 1);
        r.pos_x = {cx, 2'b00} - half_scaled;
        r.pos_y = {cy, 2'b00} - half_scaled;
        r.pos_z = {cz, 2'b00} - half_scaled;
        return r;
    endfunction

    task automatic check_field(string name, logic signed [POS_W-1:0] want,
                               logic signed [POS_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Offer one index and hold it until the block takes it. Bursts of random
    // length are separated by random gaps with valid low; most gaps are zero
    // so long back-to-back stretches occur too.
    task automatic send_index(logic [INDEX_W-1:0] index, pos_item_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0;
            if (gap > 0)
            begin
                idx_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        idx_if.valid              <= 1'b1;
        idx_if.data.hilbert_index <= index;
        do @(posedge clk); while (!idx_if.ready);
        pending_pos.push_back(want);
        burst_left--;
    endtask

    // Drop valid and wait until every owed position has come out, then let
    // the pipeline run empty before touching curve_order.
    task automatic settle_pipe();
        idx_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_pos.size() != 0) @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    task automatic write_order(order_t value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        cur_order = value;
    endtask

    // Result side: check every transfer on pos against the oldest owed
    // position. All values read here are the ones before the edge.
    always @(posedge clk)
    begin
        if (rst_n && pos_if.valid && pos_if.ready)
        begin
            if (pending_pos.size() == 0)
            begin
                $error("pos: transfer with no position owed (x=%0d y=%0d z=%0d)",
                       pos_if.data.pos_x, pos_if.data.pos_y, pos_if.data.pos_z);
                mismatch_count++;
            end
            else
            begin
                check_field("pos_x", pending_pos[0].pos_x, pos_if.data.pos_x);
                check_field("pos_y", pending_pos[0].pos_y, pos_if.data.pos_y);
                check_field("pos_z", pending_pos[0].pos_z, pos_if.data.pos_z);
                void'(pending_pos.pop_front());
            end
        end
    end

    // Receiver back-pressure: switch at random between always ready,
    // coin-flip, mostly ready and mostly stalled.
    initial
    begin
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        pos_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(40, 300);
            end
            mode_left--;
            case (mode)
                0:       pos_if.ready <= 1'b1;
                1:       pos_if.ready <= 1'($urandom_range(0, 1));
                2:       pos_if.ready <= ($urandom_range(0, 3) != 0);
                default: pos_if.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        pos_item_t  want;
        order_t     phase_order [8];
        int         ph;
        int         n;
        logic [INDEX_W-1:0] index;
        logic [INDEX_W-1:0] low_mask;

        mismatch_count = 0;
        burst_left     = 0;
        cur_order      = order_t'(ORDER_RESET);
        rst_n          <= 1'b0;
        idx_if.valid   <= 1'b0;
        idx_if.data    <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.data    <= '0;

        // Hold reset low, then release it at an edge.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: write curve_order only when a row asks for a new one.
        for (n = 0; n < DIR_ROWS; n++)
        begin
            if (dir_rows[n].ord != cur_order)
            begin
                settle_pipe();
                write_order(dir_rows[n].ord);
            end
            if (dir_rows[n].known)
            begin
                want.pos_x = POS_W'(dir_rows[n].x);
                want.pos_y = POS_W'(dir_rows[n].y);
                want.pos_z = POS_W'(dir_rows[n].z);
            end
            else
                want = decode_position(dir_rows[n].index, cur_order);
            send_index(dir_rows[n].index, want);
        end

        // Random phases: order extremes, zero and the largest 4-bit value first,
        // then any 4-bit value.
        phase_order[0] = 4'd1;
        phase_order[1] = 4'd10;
        phase_order[2] = 4'd0;
        phase_order[3] = 4'd15;
        for (ph = 4; ph < 8; ph++)
            phase_order[ph] = order_t'($urandom_range(0, 15));

        for (ph = 0; ph < 8; ph++)
        begin
            settle_pipe();
            write_order(phase_order[ph]);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                index = INDEX_W'($urandom);
                // Now and then clear the unused upper bits, so both clean and
                // dirty upper bits show up at every order below the maximum.
                if ($urandom_range(0, 3) == 0)
                begin
                    low_mask = INDEX_W'((INDEX_W'(1) << (3 * ((cur_order == 0) ? 1 :
                               ((cur_order > ORDER_MAX) ? ORDER_MAX : cur_order)))) - 1);
                    index = index & low_mask;
                end
                send_index(index, decode_position(index, cur_order));
            end
        end

        // Drain: wait for every owed position, then let the pipeline run empty so a
        // stray extra transfer would still be caught.
        settle_pipe();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
